### design/hsv_pkg.sv
`timescale 1ns / 1ps
// Shared widths and fixed-point constants for the HSV to RGB converter.
// No dependencies; imported by hsv_level and hsv_to_rgb_converter_top.
package hsv_pkg;

	// Channel fractions are numerators over 600000; the largest valid one is 600000.
	localparam int NUM_W   = 20;
	localparam int LEVEL_W = 8;

	// level = floor((17*n + 20000) / 40000), written as floor(floor(x/64)/625).
	localparam int SCALED_W    = 24;
	localparam int SHIFT_BITS  = 6;
	localparam int QUOT_W      = SCALED_W - SHIFT_BITS;
	localparam int RECIP_SHIFT = 21;
	localparam int RECIP_W     = 12;
	localparam int PROD_W      = QUOT_W + RECIP_W;
	localparam int EST_W       = PROD_W - RECIP_SHIFT;
	localparam int REM_W       = QUOT_W + 1;

	localparam logic [RECIP_W-1:0]  RECIP_625 = RECIP_W'(3355);
	localparam logic [9:0]          DIV_625   = 10'd625;
	localparam logic [SCALED_W-1:0] ROUND_ADD = SCALED_W'(20000);

endpackage

### design/hsv_level.sv
`timescale 1ns / 1ps
// Converts one channel numerator (over 600000) into an 8-bit level, rounding half up.
// Depends on hsv_pkg; four register stages, one new numerator per cycle.
module hsv_level
	import hsv_pkg::*;
(
	input  logic               clk,
	input  logic [NUM_W-1:0]   num,
	output logic [LEVEL_W-1:0] level
);

	logic [NUM_W-1:0]    num_s3;
	logic [SCALED_W-1:0] x_s4;
	logic [QUOT_W-1:0]   y_s5;
	logic [EST_W-1:0]    est_s5;
	logic [LEVEL_W-1:0]  level_s6;

	logic [QUOT_W-1:0] y_c;
	logic [PROD_W-1:0] prod_c;
	logic [REM_W-1:0]  back_c;
	logic [REM_W-1:0]  rem_c;
	logic [EST_W-1:0]  quot_c;

	always_comb begin
		y_c    = x_s4[SCALED_W-1:SHIFT_BITS];
		prod_c = PROD_W'(y_c) * PROD_W'(RECIP_625);
		// The estimate is the true quotient or one below it.
		back_c = REM_W'(REM_W'(est_s5) * REM_W'(DIV_625));
		rem_c  = REM_W'(y_s5) - back_c;
		quot_c = (rem_c >= REM_W'(DIV_625)) ? est_s5 + EST_W'(1) : est_s5;
	end

	always_ff @(posedge clk) begin
		num_s3   <= num;
		x_s4     <= (SCALED_W'(num_s3) << 4) + SCALED_W'(num_s3) + ROUND_ADD;
		y_s5     <= y_c;
		est_s5   <= prod_c[PROD_W-1:RECIP_SHIFT];
		level_s6 <= quot_c[LEVEL_W-1:0];
	end

	assign level = level_s6;

endmodule

### design/hsv_to_rgb_converter_top.sv
`timescale 1ns / 1ps
// HSV to RGB converter: six-stage pipeline, one item accepted every cycle, busy is always low.
// An item accepted at a clock edge raises done once it reaches the last stage register,
// and its result is taken while done is high.
// Results are held one cycle only; the receiver cannot stall, so nothing ever backs up.
// Reset (arst_n low, asynchronous) clears the valid bits only; no result is pending after it.
// Depends on hsv_pkg and hsv_level.
module hsv_to_rgb_converter_top
	import hsv_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [9:0]         pixel_tag,
	input  logic [8:0]         hue_degrees,
	input  logic [6:0]         saturation_pct,
	input  logic [6:0]         value_pct,
	output logic               done,
	output logic [9:0]         tag_out,
	output logic [LEVEL_W-1:0] red_level,
	output logic [LEVEL_W-1:0] green_level,
	output logic [LEVEL_W-1:0] blue_level,
	output logic               invalid_input
);

	// Hue sectors of sixty degrees each; hue 360 falls in the last one and, since its
	// middle component is zero there, gives the same colors as hue 0.
	typedef enum logic [2:0] {
		SEC_RY, SEC_YG, SEC_GC, SEC_CB, SEC_BM, SEC_MR
	} sector_t;

	localparam int PIPE_N = 6;

	// Valid bit, tag and invalid flag travel down all six stages with the data.
	logic [PIPE_N-1:0] vld_q;
	logic [9:0]        tag_q [PIPE_N];
	logic              bad_q [PIPE_N];

	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Stage 1: range check, sector, distance from the sector middle, and the two
	// small products s*v and v*(100-s).
	sector_t     sec_c, sec_s1, sec_s2;
	logic [8:0]  t_c;
	logic [5:0]  d_c, d_s1;
	logic [13:0] sv_s1, vs_s1;
	logic        bad_c;

	always_comb begin
		bad_c = (hue_degrees > 9'd360) || (saturation_pct > 7'd100) || (value_pct > 7'd100);
		if (hue_degrees < 9'd60)        sec_c = SEC_RY;
		else if (hue_degrees < 9'd120)  sec_c = SEC_YG;
		else if (hue_degrees < 9'd180)  sec_c = SEC_GC;
		else if (hue_degrees < 9'd240)  sec_c = SEC_CB;
		else if (hue_degrees < 9'd300)  sec_c = SEC_BM;
		else                            sec_c = SEC_MR;
		// Hue modulo 120, taken by compares; exact for hues up to 479 of the 9-bit maximum 511.
		if (hue_degrees < 9'd120)       t_c = hue_degrees;
		else if (hue_degrees < 9'd240)  t_c = hue_degrees - 9'd120;
		else if (hue_degrees < 9'd360)  t_c = hue_degrees - 9'd240;
		else                            t_c = hue_degrees - 9'd360;
		d_c = (t_c >= 9'd60) ? 6'(t_c - 9'd60) : 6'(9'd60 - t_c);
	end

	// Stage 2: numerators over 600000 for chroma, middle component and offset.
	logic [NUM_W-1:0] cn_s2, xn_s2, mn_s2;

	always_ff @(posedge clk) begin
		sec_s1 <= sec_c;
		d_s1   <= d_c;
		sv_s1  <= 14'(saturation_pct) * 14'(value_pct);
		vs_s1  <= 14'(value_pct) * 14'(7'd100 - saturation_pct);
		sec_s2 <= sec_s1;
		cn_s2  <= NUM_W'(sv_s1) * NUM_W'(60);
		xn_s2  <= NUM_W'(sv_s1) * NUM_W'(6'd60 - d_s1);
		mn_s2  <= NUM_W'(vs_s1) * NUM_W'(60);
	end

	// Route chroma and middle component to the channels by sector and add the offset.
	// An invalid item gets zero numerators, which round to level zero.
	logic [NUM_W-1:0] rn_c, gn_c, bn_c;

	always_comb begin
		rn_c = '0;
		gn_c = '0;
		bn_c = '0;
		case (sec_s2)
			SEC_RY: begin rn_c = cn_s2; gn_c = xn_s2; end
			SEC_YG: begin rn_c = xn_s2; gn_c = cn_s2; end
			SEC_GC: begin gn_c = cn_s2; bn_c = xn_s2; end
			SEC_CB: begin gn_c = xn_s2; bn_c = cn_s2; end
			SEC_BM: begin rn_c = xn_s2; bn_c = cn_s2; end
			default: begin rn_c = cn_s2; bn_c = xn_s2; end
		endcase
		if (bad_q[1]) begin
			rn_c = '0;
			gn_c = '0;
			bn_c = '0;
		end else begin
			rn_c = rn_c + mn_s2;
			gn_c = gn_c + mn_s2;
			bn_c = bn_c + mn_s2;
		end
	end

	// Stages 3 to 6: scaling by 255 and rounding, one unit per channel.
	hsv_level u_red   (.clk(clk), .num(rn_c), .level(red_level));
	hsv_level u_green (.clk(clk), .num(gn_c), .level(green_level));
	hsv_level u_blue  (.clk(clk), .num(bn_c), .level(blue_level));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[PIPE_N-2:0], accept};
		end
	end

	always_ff @(posedge clk) begin
		tag_q[0] <= pixel_tag;
		bad_q[0] <= bad_c;
		for (int i = 1; i < PIPE_N; i++) begin
			tag_q[i] <= tag_q[i-1];
			bad_q[i] <= bad_q[i-1];
		end
	end

	assign done          = vld_q[PIPE_N-1];
	assign tag_out       = tag_q[PIPE_N-1];
	assign invalid_input = bad_q[PIPE_N-1];

endmodule
